### rtl/rtlpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlpm_pkg
// Shared widths, operation and status codes, controller/datapath structs and
// helper functions for the IPv4 route table with longest-prefix-match lookup.
// ----------------------------------------------------------------------------
package rtlpm_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam int FUNC_W  = 3;
   localparam int ADDR_W  = 32;
   localparam int ORD_W   = 8;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 9;
   localparam int LEN_W   = 6;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SNAPSHOT = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NOTFOUND = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // latch the request and start the operation
      logic issue;  // read the next table entry
      logic eval;   // the scan is active, evaluate the entry read last cycle
      logic emit;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_scan;   // the offered request walks the table
      logic issue_done;  // every entry has been read
      logic scan_stop;   // the entry under evaluation ends the scan
      logic out_free;    // the result register can take a new result
   } stat_type;

   // Population count done per byte so that each chain stays short.
   function automatic logic [LEN_W-1:0] popcount32(input logic [ADDR_W-1:0] value);
      logic [3:0]       byte_cnt [4];
      logic [LEN_W-1:0] total;
      for (int b = 0; b < 4; b++) begin
         byte_cnt[b] = 4'd0;
         for (int k = 0; k < 8; k++) begin
            byte_cnt[b] = byte_cnt[b] + {3'd0, value[8*b+k]};
         end
      end
      total = {2'd0, byte_cnt[0]} + {2'd0, byte_cnt[1]} +
              {2'd0, byte_cnt[2]} + {2'd0, byte_cnt[3]};
      return total;
   endfunction

endpackage

### rtl/rtlpm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlpm_req_if
// Request channel of the route table: operation code and its operands.
// ----------------------------------------------------------------------------
interface rtlpm_req_if;
   import rtlpm_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] addr;
   logic [ADDR_W-1:0] mask;
   logic [ADDR_W-1:0] next_gateway;
   logic [ORD_W-1:0]  ordinal;

   modport source (output valid, func, addr, mask, next_gateway, ordinal, input ready);
   modport sink   (input valid, func, addr, mask, next_gateway, ordinal, output ready);
endinterface

### rtl/rtlpm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlpm_rsp_if
// Response channel of the route table: status, lookup answer, snapshot entry.
// ----------------------------------------------------------------------------
interface rtlpm_rsp_if;
   import rtlpm_pkg::*;

   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [ADDR_W-1:0]  hop_addr;
   logic [ADDR_W-1:0]  entry_network;
   logic [ADDR_W-1:0]  entry_mask;
   logic [ADDR_W-1:0]  entry_gateway;
   logic [COUNT_W-1:0] route_count;

   modport source (output valid, status, hop_addr, entry_network, entry_mask,
                   entry_gateway, route_count, input ready);
   modport sink   (input valid, status, hop_addr, entry_network, entry_mask,
                   entry_gateway, route_count, output ready);
endinterface

### rtl/rtlpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlpm_ctrl
// Operation sequencer: accepts a request, runs the table scan and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module rtlpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output rtlpm_pkg::cmd_type  cmd,
   input  rtlpm_pkg::stat_type stat
);
   import rtlpm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.load  = req_valid && req_ready;
      cmd.eval  = (state_ff == ST_SCAN);
      cmd.issue = (state_ff == ST_SCAN) && !stat.issue_done && !stat.scan_stop;
      cmd.emit  = (state_ff == ST_FINISH) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = stat.need_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (stat.scan_stop) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/rtlpm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlpm_dpath
// Route table storage, one-entry-per-cycle scan pipeline, per-operation
// evaluation and the result register.
// ----------------------------------------------------------------------------
module rtlpm_dpath #(
   parameter int TABLE_DEPTH = rtlpm_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rtlpm_pkg::cmd_type                  cmd,
   output rtlpm_pkg::stat_type                 stat,
   input  logic [rtlpm_pkg::FUNC_W-1:0]        req_func,
   input  logic [rtlpm_pkg::ADDR_W-1:0]        req_addr,
   input  logic [rtlpm_pkg::ADDR_W-1:0]        req_mask,
   input  logic [rtlpm_pkg::ADDR_W-1:0]        req_next_gateway,
   input  logic [rtlpm_pkg::ORD_W-1:0]         req_ordinal,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rtlpm_pkg::STAT_W-1:0]        rsp_status,
   output logic [rtlpm_pkg::ADDR_W-1:0]        rsp_hop_addr,
   output logic [rtlpm_pkg::ADDR_W-1:0]        rsp_entry_network,
   output logic [rtlpm_pkg::ADDR_W-1:0]        rsp_entry_mask,
   output logic [rtlpm_pkg::ADDR_W-1:0]        rsp_entry_gateway,
   output logic [rtlpm_pkg::COUNT_W-1:0]       rsp_route_count
);
   import rtlpm_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

   // Table storage. Data of free slots is never observed, so the memories
   // need no clearing; the valid bits live in flip-flops.
   logic [ADDR_W-1:0] net_mem  [TABLE_DEPTH];
   logic [ADDR_W-1:0] mask_mem [TABLE_DEPTH];
   logic [ADDR_W-1:0] gw_mem   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0]       count_ff;

   // Latched request.
   logic [FUNC_W-1:0] func_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] mask_ff;
   logic [ADDR_W-1:0] gw_ff;
   logic [ORD_W-1:0]  ord_ff;

   // Scan pipeline.
   logic [CNT_W-1:0]  iss_cnt_ff;
   logic [IDX_W-1:0]  iss_idx;
   logic              s1_vld_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic              s1_bit_ff;
   logic [ADDR_W-1:0] rd_net_ff;
   logic [ADDR_W-1:0] rd_mask_ff;
   logic [ADDR_W-1:0] rd_gw_ff;

   // Operation accumulators.
   logic              found_ff;
   logic [COUNT_W-1:0] seen_ff;
   logic [LEN_W-1:0]  best_len_ff;
   logic [ADDR_W-1:0] best_gw_ff;
   logic [ADDR_W-1:0] e_net_ff;
   logic [ADDR_W-1:0] e_mask_ff;
   logic [ADDR_W-1:0] e_gw_ff;

   // Result register.
   logic               out_valid_ff;
   logic [STAT_W-1:0]  out_status_ff;
   logic [ADDR_W-1:0]  out_hop_ff;
   logic [ADDR_W-1:0]  out_net_ff;
   logic [ADDR_W-1:0]  out_mask_ff;
   logic [ADDR_W-1:0]  out_gw_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic              upd;
   logic              entry_match;
   logic [LEN_W-1:0]  cand_len;
   logic              hit;
   logic              lk_better;
   logic              wr_en;
   logic              rm_hit;
   logic [STAT_W-1:0] res_status;
   logic [ADDR_W-1:0] res_hop;

   assign iss_idx = iss_cnt_ff[IDX_W-1:0];
   assign upd     = s1_vld_ff && cmd.eval;

   assign entry_match = (addr_ff & rd_mask_ff) == rd_net_ff;
   assign cand_len    = popcount32(rd_mask_ff);

   always_comb begin
      hit = 1'b0;
      unique case (func_ff)
         FUNC_ADD:      hit = !s1_bit_ff;
         FUNC_REMOVE:   hit = s1_bit_ff && entry_match;
         FUNC_SNAPSHOT: hit = s1_bit_ff && (seen_ff == {1'b0, ord_ff});
         default:       hit = 1'b0;
      endcase
   end

   assign lk_better = upd && (func_ff == FUNC_LOOKUP) && s1_bit_ff && entry_match &&
                      (!found_ff || (cand_len > best_len_ff));
   assign wr_en     = upd && hit && (func_ff == FUNC_ADD);
   assign rm_hit    = upd && hit && (func_ff == FUNC_REMOVE);

   always_comb begin
      stat.need_scan  = (req_func == FUNC_LOOKUP) || (req_func == FUNC_ADD) ||
                        (req_func == FUNC_REMOVE) || (req_func == FUNC_SNAPSHOT);
      stat.issue_done = (iss_cnt_ff == DEPTH_CNT);
      stat.scan_stop  = s1_vld_ff && (hit || (s1_idx_ff == LAST_IDX));
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   // Table memories: one write port for add, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         net_mem[s1_idx_ff]  <= addr_ff & mask_ff;
         mask_mem[s1_idx_ff] <= mask_ff;
         gw_mem[s1_idx_ff]   <= gw_ff;
      end
      rd_net_ff  <= net_mem[iss_idx];
      rd_mask_ff <= mask_mem[iss_idx];
      rd_gw_ff   <= gw_mem[iss_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.load && (req_func == FUNC_CLEAR)) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (wr_en) begin
         valid_ff[s1_idx_ff] <= 1'b1;
         count_ff            <= count_ff + 1'b1;
      end else if (rm_hit) begin
         valid_ff[s1_idx_ff] <= 1'b0;
         count_ff            <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         iss_cnt_ff <= '0;
         found_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         if (cmd.load) begin
            iss_cnt_ff <= '0;
            found_ff   <= 1'b0;
         end else begin
            if (cmd.issue) begin
               iss_cnt_ff <= iss_cnt_ff + 1'b1;
            end
            if ((upd && hit) || lk_better) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= iss_idx;
      s1_bit_ff <= valid_ff[iss_idx];
      if (cmd.load) begin
         func_ff     <= req_func;
         addr_ff     <= req_addr;
         mask_ff     <= req_mask;
         gw_ff       <= req_next_gateway;
         ord_ff      <= req_ordinal;
         seen_ff     <= '0;
         best_len_ff <= '0;
         best_gw_ff  <= '0;
         e_net_ff    <= '0;
         e_mask_ff   <= '0;
         e_gw_ff     <= '0;
      end else begin
         if (lk_better) begin
            best_len_ff <= cand_len;
            best_gw_ff  <= rd_gw_ff;
         end
         if (upd && (func_ff == FUNC_SNAPSHOT) && s1_bit_ff) begin
            seen_ff <= seen_ff + 1'b1;
            if (hit) begin
               e_net_ff  <= rd_net_ff;
               e_mask_ff <= rd_mask_ff;
               e_gw_ff   <= rd_gw_ff;
            end
         end
      end
   end

   always_comb begin
      res_status = STATUS_OK;
      unique case (func_ff)
         FUNC_LOOKUP, FUNC_REMOVE, FUNC_SNAPSHOT:
            res_status = found_ff ? STATUS_OK : STATUS_NOTFOUND;
         FUNC_ADD:
            res_status = found_ff ? STATUS_OK : STATUS_FULL;
         default:
            res_status = STATUS_OK;
      endcase
      res_hop = '0;
      if ((func_ff == FUNC_LOOKUP) && found_ff) begin
         // A zero gateway marks a directly attached network.
         res_hop = (best_gw_ff == '0) ? addr_ff : best_gw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_status_ff <= res_status;
         out_hop_ff    <= res_hop;
         out_net_ff    <= e_net_ff;
         out_mask_ff   <= e_mask_ff;
         out_gw_ff     <= e_gw_ff;
         out_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_hop_addr      = out_hop_ff;
   assign rsp_entry_network = out_net_ff;
   assign rsp_entry_mask    = out_mask_ff;
   assign rsp_entry_gateway = out_gw_ff;
   assign rsp_route_count   = out_count_ff;

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("route count differs from the number of valid entries");

   a_add_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (func_ff == FUNC_ADD) && !valid_ff[s1_idx_ff])
      else $error("add wrote into an occupied slot");

   a_remove_frees_slot: assert property (@(posedge clock) disable iff (reset)
      rm_hit |=> !valid_ff[$past(s1_idx_ff)])
      else $error("removed entry is still valid");

endmodule

### rtl/ipv4_route_table_lpm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_route_table_lpm_unit
// IPv4 route table with add, remove, clear, longest-prefix lookup and
// snapshot, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Usage: operations arrive on req_ch (func, addr, mask, next_gateway,
// ordinal) and each transfer produces exactly one result on rsp_ch
// (status, hop_addr, entry fields, route_count after the operation).
// Lookup walks every entry before its result is loaded. Add, remove and
// snapshot stop at the entry that satisfies them; clear and unused codes
// skip the scan and go straight to the result. The scan rate is set by
// the single registered read port of the table memory, read once per
// entry per cycle. One operation is in flight at a time; req_ch.ready
// returns in the cycle after the result is loaded, and a new request may
// enter while a result still waits on rsp_ch.
// If the receiver stalls, the result holds in the output register and the
// next operation waits before loading its own result.
// Reset (synchronous) empties the table at once and drops any pending
// result; there is no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_route_table_lpm_unit #(
   parameter int TABLE_DEPTH = rtlpm_pkg::DEFAULT_TABLE_DEPTH
) (
   input logic         clock,
   input logic         reset,
   rtlpm_req_if.sink   req_ch,
   rtlpm_rsp_if.source rsp_ch
);
   import rtlpm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rtlpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rtlpm_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_ch.func),
      .req_addr          (req_ch.addr),
      .req_mask          (req_ch.mask),
      .req_next_gateway  (req_ch.next_gateway),
      .req_ordinal       (req_ch.ordinal),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_hop_addr      (rsp_ch.hop_addr),
      .rsp_entry_network (rsp_ch.entry_network),
      .rsp_entry_mask    (rsp_ch.entry_mask),
      .rsp_entry_gateway (rsp_ch.entry_gateway),
      .rsp_route_count   (rsp_ch.route_count)
   );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipv4_route_table_lpm_unit. Route adds, removes,
// clears, lookups and snapshots are sent with random pacing on both channels.
// A behavioral copy of the route table predicts each response, and every
// response is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import rtlpm_pkg::*;

   localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
   localparam int RANDOM_OPS   = 1100;
   localparam int CHUNK_OPS    = 100;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   // Codes the block treats as no operation.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] next_gateway;
      logic [ORD_W-1:0]  ordinal;
   } route_op_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [ADDR_W-1:0]  hop_addr;
      logic [ADDR_W-1:0]  entry_network;
      logic [ADDR_W-1:0]  entry_mask;
      logic [ADDR_W-1:0]  entry_gateway;
      logic [COUNT_W-1:0] route_count;
   } route_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtlpm_req_if req_ch ();
   rtlpm_rsp_if rsp_ch ();

   ipv4_route_table_lpm_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the route table.
   logic              route_valid [DEPTH];
   logic [ADDR_W-1:0] route_net   [DEPTH];
   logic [ADDR_W-1:0] route_mask  [DEPTH];
   logic [ADDR_W-1:0] route_gw    [DEPTH];

   route_rsp_type pending_rsp_q [$];
   int            error_count = 0;
   int            cycle_count = 0;
   bit            pacing      = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one operation to the shadow table and returns the response.
   function automatic route_rsp_type apply_route_op(input route_op_type op);
      route_rsp_type rsp;
      int            best;
      int            best_len;
      int            len;
      int            seen;
      rsp        = '0;
      rsp.status = STATUS_OK;
      case (op.func)
         FUNC_LOOKUP: begin
            best     = -1;
            best_len = 0;
            for (int i = 0; i < DEPTH; i++) begin
               if (route_valid[i] && (op.addr & route_mask[i]) == route_net[i]) begin
                  len = 0;
                  for (int b = 0; b < ADDR_W; b++) len += route_mask[i][b];
                  // Strictly longer only, so the lower index keeps a tie.
                  if (best < 0 || len > best_len) begin
                     best     = i;
                     best_len = len;
                  end
               end
            end
            if (best < 0) rsp.status = STATUS_NOTFOUND;
            else rsp.hop_addr = (route_gw[best] == '0) ? op.addr : route_gw[best];
         end
         FUNC_ADD: begin
            rsp.status = STATUS_FULL;
            for (int i = 0; i < DEPTH; i++) begin
               if (!route_valid[i] && rsp.status == STATUS_FULL) begin
                  route_valid[i] = 1'b1;
                  route_net[i]   = op.addr & op.mask;
                  route_mask[i]  = op.mask;
                  route_gw[i]    = op.next_gateway;
                  rsp.status     = STATUS_OK;
               end
            end
         end
         FUNC_REMOVE: begin
            rsp.status = STATUS_NOTFOUND;
            for (int i = 0; i < DEPTH; i++) begin
               if (route_valid[i] && rsp.status == STATUS_NOTFOUND &&
                   (op.addr & route_mask[i]) == route_net[i]) begin
                  route_valid[i] = 1'b0;
                  rsp.status     = STATUS_OK;
               end
            end
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < DEPTH; i++) begin
               route_valid[i] = 1'b0;
               route_net[i]   = '0;
               route_mask[i]  = '0;
               route_gw[i]    = '0;
            end
         end
         FUNC_SNAPSHOT: begin
            rsp.status = STATUS_NOTFOUND;
            seen       = 0;
            for (int i = 0; i < DEPTH; i++) begin
               if (route_valid[i]) begin
                  if (seen == int'(op.ordinal)) begin
                     rsp.entry_network = route_net[i];
                     rsp.entry_mask    = route_mask[i];
                     rsp.entry_gateway = route_gw[i];
                     rsp.status        = STATUS_OK;
                  end
                  seen++;
               end
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < DEPTH; i++) rsp.route_count += COUNT_W'(route_valid[i]);
      return rsp;
   endfunction

   function automatic route_op_type make_op(input logic [FUNC_W-1:0] func,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [ADDR_W-1:0] mask,
                                            input logic [ADDR_W-1:0] gw,
                                            input logic [ORD_W-1:0]  ord);
      route_op_type op;
      op.func         = func;
      op.addr         = addr;
      op.mask         = mask;
      op.next_gateway = gw;
      op.ordinal      = ord;
      return op;
   endfunction

   function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
      if (len == 0) return '0;
      return ~32'h0 << (ADDR_W - len);
   endfunction

   // When a randomly chosen slot holds a route, mostly an address inside it, so lookups and removes hit.
   function automatic logic [ADDR_W-1:0] addr_near_route();
      int i;
      i = $urandom_range(0, DEPTH - 1);
      if (route_valid[i] && $urandom_range(0, 9) < 7)
         return route_net[i] | ($urandom & ~route_mask[i]);
      return $urandom;
   endfunction

   function automatic route_op_type random_op(input int add_weight);
      route_op_type op;
      int           pick;
      op.addr         = addr_near_route();
      op.mask         = ($urandom_range(0, 4) == 0) ? $urandom
                                                    : prefix_mask($urandom_range(0, ADDR_W));
      op.next_gateway = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
      op.ordinal      = ($urandom_range(0, 3) == 0) ? ORD_W'($urandom_range(0, 255))
                                                    : ORD_W'($urandom_range(0, DEPTH + 1));
      pick = $urandom_range(0, 99);
      if (pick < add_weight) op.func = FUNC_ADD;
      else if (pick < add_weight + 15) op.func = FUNC_REMOVE;
      else if (pick < add_weight + 27) op.func = FUNC_SNAPSHOT;
      else if (pick < add_weight + 29) op.func = FUNC_CLEAR;
      else if (pick < add_weight + 31)
         op.func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      else op.func = FUNC_LOOKUP;
      return op;
   endfunction

   // Presents one request and records its prediction once it transfers.
   task automatic send_op(input route_op_type op);
      int gap;
      gap = pacing ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid        = 1'b1;
      req_ch.func         = op.func;
      req_ch.addr         = op.addr;
      req_ch.mask         = op.mask;
      req_ch.next_gateway = op.next_gateway;
      req_ch.ordinal      = op.ordinal;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp_q.push_back(apply_route_op(op));
   endtask

   // The request is withdrawn first so that it cannot transfer a second time.
   task automatic wait_for_responses();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_op(make_op(FUNC_LOOKUP, 32'hC0A80101, '0, '0, '0));
      send_op(make_op(FUNC_REMOVE, 32'hFFFFFFFF, '0, '0, '0));
   endtask

   // Fills every slot, then one add more must report a full table.
   task automatic test_fill_and_overflow();
      send_op(make_op(FUNC_ADD, 32'h00000000, 32'h00000000, 32'h00000000, '0));
      send_op(make_op(FUNC_ADD, 32'h0A000000, 32'hFF000000, 32'h0A0000FE, '0));
      send_op(make_op(FUNC_ADD, 32'hFFFFFF05, 32'h000000FF, 32'hC0A80001, '0));
      send_op(make_op(FUNC_ADD, 32'h0A010000, 32'hFFFF0000, 32'h00000000, '0));
      send_op(make_op(FUNC_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, '0));
      for (int i = 5; i < DEPTH; i++)
         send_op(make_op(FUNC_ADD, {8'hAC, 24'($urandom)},
                         prefix_mask($urandom_range(16, 30)), $urandom, '0));
      send_op(make_op(FUNC_ADD, 32'h01020304, 32'hFFFFFF00, 32'h0A0A0A0A, '0));
   endtask

   task automatic test_longest_match();
      // Two eight-bit masks match here; the lower slot has to win.
      send_op(make_op(FUNC_LOOKUP, 32'h0A000005, '0, '0, '0));
      // Directly attached route: the address itself is the next hop.
      send_op(make_op(FUNC_LOOKUP, 32'h0A010203, '0, '0, '0));
      send_op(make_op(FUNC_LOOKUP, 32'hFFFFFFFF, '0, '0, '0));
   endtask

   task automatic test_snapshot_range();
      send_op(make_op(FUNC_SNAPSHOT, '0, '0, '0, 8'(DEPTH - 1)));
      send_op(make_op(FUNC_SNAPSHOT, '0, '0, '0, 8'hFF));
   endtask

   task automatic test_remove_default();
      // The default route in slot zero matches first and is the one freed.
      send_op(make_op(FUNC_REMOVE, 32'h0A000005, '0, '0, '0));
      send_op(make_op(FUNC_LOOKUP, 32'h12345678, '0, '0, '0));
   endtask

   task automatic test_unused_codes();
      send_op(make_op(FUNC_SPARE_LAST, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF));
   endtask

   task automatic test_clear();
      send_op(make_op(FUNC_CLEAR, $urandom, $urandom, $urandom, 8'($urandom)));
   endtask

   // Chunks alternate between a churning table and one that runs full, and
   // some chunks run without idle cycles on either channel.
   task automatic test_random_traffic();
      int add_weight;
      for (int chunk = 0; chunk < RANDOM_OPS / CHUNK_OPS; chunk++) begin
         pacing     = (chunk % 3) != 2;
         add_weight = (chunk % 2 == 1) ? 45 : 20;
         for (int n = 0; n < CHUNK_OPS; n++) begin
            send_op(random_op(add_weight));
            if (chunk == 5 && n == CHUNK_OPS / 2) wait_for_responses();
         end
      end
   endtask

   initial begin : rsp_pacing
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = pacing ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            @(negedge clock);
            rsp_ch.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready));
      end
   end

   task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_v,
                              input logic [ADDR_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      route_rsp_type exp_rsp;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            exp_rsp = pending_rsp_q.pop_front();
            check_field("status", ADDR_W'(exp_rsp.status), ADDR_W'(rsp_ch.status));
            check_field("hop_addr", exp_rsp.hop_addr, rsp_ch.hop_addr);
            check_field("entry_network", exp_rsp.entry_network, rsp_ch.entry_network);
            check_field("entry_mask", exp_rsp.entry_mask, rsp_ch.entry_mask);
            check_field("entry_gateway", exp_rsp.entry_gateway, rsp_ch.entry_gateway);
            check_field("route_count", ADDR_W'(exp_rsp.route_count),
                        ADDR_W'(rsp_ch.route_count));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_LOOKUP;
      req_ch.addr         = '0;
      req_ch.mask         = '0;
      req_ch.next_gateway = '0;
      req_ch.ordinal      = '0;
      for (int i = 0; i < DEPTH; i++) begin
         route_valid[i] = 1'b0;
         route_net[i]   = '0;
         route_mask[i]  = '0;
         route_gw[i]    = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_fill_and_overflow();
      test_longest_match();
      test_snapshot_range();
      test_remove_default();
      test_unused_codes();
      test_clear();
      test_random_traffic();

      @(negedge clock);
      req_ch.valid = 1'b0;
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_rsp_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
rtl/rtlpm_pkg.sv
rtl/rtlpm_req_if.sv
rtl/rtlpm_rsp_if.sv
rtl/rtlpm_ctrl.sv
rtl/rtlpm_dpath.sv
rtl/ipv4_route_table_lpm_unit.sv
tb/testbench.sv
